@@ src/qte_pkg.sv @@
// Shared types and constants for the quaternion to Euler angle converter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package qte_pkg;

    localparam int CW       = 40;   // CORDIC x/y width
    localparam int AW       = 35;   // CORDIC angle width, Q30 radians
    localparam int SQ_W     = 62;   // square root remainder/root width
    localparam int SQ_CELLS = 31;   // one cell per result bit of the root

    localparam logic signed [AW-1:0] PI_Q30 = 35'sd3373259426;

    localparam logic [47:0] RECIP_82   = 48'd13094412;   // floor(2^30 / 82)
    localparam logic [51:0] ANGLE_GAIN = 52'd36672;      // 57.3 * 64 * 10
    localparam logic [51:0] ANGLE_BIAS = 52'd5368709120; // 5 * 2^30
    localparam logic [43:0] RECIP_5    = 44'd3355444;    // ceil(2^24 / 5)

    localparam int PITCH_LIMIT = 5761;
    localparam int YAW_LIMIT   = 11521;

    localparam logic [30:0] ATAN_Q30 [32] = '{
        31'd843314857, 31'd497837829, 31'd263043837, 31'd133525159,
        31'd67021687,  31'd33543516,  31'd16775851,  31'd8388437,
        31'd4194283,   31'd2097149,   31'd1048576,   31'd524288,
        31'd262144,    31'd131072,    31'd65536,     31'd32768,
        31'd16384,     31'd8192,      31'd4096,      31'd2048,
        31'd1024,      31'd512,       31'd256,       31'd128,
        31'd64,        31'd32,        31'd16,        31'd8,
        31'd4,         31'd2,         31'd1,         31'd0
    };

    typedef logic signed [CW-1:0] cxy_t;
    typedef logic signed [AW-1:0] cang_t;
    typedef logic [SQ_W-1:0]      sq_t;

endpackage
`default_nettype wire

@@ src/qte_sqrt_cell.sv @@
// One step of the restoring integer square root: settles one root bit.
// Depends on qte_pkg.
`timescale 1ns / 1ps
`default_nettype none
module qte_sqrt_cell #(
    parameter int BIT_POS = 60
) (
    input  wire logic          aclk,
    input  wire logic          en,
    input  wire qte_pkg::sq_t  v_in,
    input  wire qte_pkg::sq_t  r_in,
    output qte_pkg::sq_t       v_out,
    output qte_pkg::sq_t       r_out
);
    import qte_pkg::*;

    sq_t bit_val;
    sq_t trial;
    sq_t v_reg;
    sq_t r_reg;

    assign bit_val = SQ_W'(1) << BIT_POS;
    assign trial   = r_in + bit_val;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (v_in >= trial) begin
                v_reg <= v_in - trial;
                r_reg <= (r_in >> 1) + bit_val;
            end else begin
                v_reg <= v_in;
                r_reg <= r_in >> 1;
            end
        end
    end

    assign v_out = v_reg;
    assign r_out = r_reg;
endmodule
`default_nettype wire

@@ src/qte_cordic_pre.sv @@
// CORDIC entry cell: folds a negative x into the right half plane by pi.
// Depends on qte_pkg.
`timescale 1ns / 1ps
`default_nettype none
module qte_cordic_pre (
    input  wire logic          aclk,
    input  wire logic          en,
    input  wire qte_pkg::cxy_t x_in,
    input  wire qte_pkg::cxy_t y_in,
    output qte_pkg::cxy_t      x_out,
    output qte_pkg::cxy_t      y_out,
    output qte_pkg::cang_t     a_out,
    output logic               zero_out
);
    import qte_pkg::*;

    cxy_t  x_reg;
    cxy_t  y_reg;
    cang_t a_reg;
    logic  zero_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            zero_reg <= (x_in == '0) && (y_in == '0);
            if (x_in[CW-1]) begin
                a_reg <= y_in[CW-1] ? -PI_Q30 : PI_Q30;
                x_reg <= -x_in;
                y_reg <= -y_in;
            end else begin
                a_reg <= '0;
                x_reg <= x_in;
                y_reg <= y_in;
            end
        end
    end

    assign x_out    = x_reg;
    assign y_out    = y_reg;
    assign a_out    = a_reg;
    assign zero_out = zero_reg;
endmodule
`default_nettype wire

@@ src/qte_cordic_cell.sv @@
// One vectoring CORDIC micro-rotation by atan(2^-IDX).
// Depends on qte_pkg for widths and the arctangent table.
`timescale 1ns / 1ps
`default_nettype none
module qte_cordic_cell #(
    parameter int IDX = 0
) (
    input  wire logic          aclk,
    input  wire logic          en,
    input  wire qte_pkg::cxy_t x_in,
    input  wire qte_pkg::cxy_t y_in,
    input  wire qte_pkg::cang_t a_in,
    input  wire logic          zero_in,
    output qte_pkg::cxy_t      x_out,
    output qte_pkg::cxy_t      y_out,
    output qte_pkg::cang_t     a_out,
    output logic               zero_out
);
    import qte_pkg::*;

    cxy_t  xs;
    cxy_t  ys;
    cang_t step;
    cxy_t  x_reg;
    cxy_t  y_reg;
    cang_t a_reg;
    logic  zero_reg;

    assign xs   = x_in >>> IDX;
    assign ys   = y_in >>> IDX;
    assign step = cang_t'(ATAN_Q30[IDX]);

    always_ff @(posedge aclk) begin
        if (en) begin
            zero_reg <= zero_in;
            if (!y_in[CW-1]) begin
                x_reg <= x_in + ys;
                y_reg <= y_in - xs;
                a_reg <= a_in + step;
            end else begin
                x_reg <= x_in - ys;
                y_reg <= y_in + xs;
                a_reg <= a_in - step;
            end
        end
    end

    assign x_out    = x_reg;
    assign y_out    = y_reg;
    assign a_out    = a_reg;
    assign zero_out = zero_reg;
endmodule
`default_nettype wire

@@ src/qte_angle_scale.sv @@
// Q30 radians to rounded, saturated 1/64 degree units over three stages.
// Depends on qte_pkg.
`timescale 1ns / 1ps
`default_nettype none
module qte_angle_scale #(
    parameter int OW    = 14,
    parameter int LIMIT = 5761
) (
    input  wire logic           aclk,
    input  wire logic           en,
    input  wire qte_pkg::cang_t a_in,
    input  wire logic           zero_in,
    output logic signed [OW-1:0] angle_out
);
    import qte_pkg::*;

    logic [AW-1:0]   mag;
    logic [51:0]     p1_reg;
    logic            neg1_reg;
    logic [43:0]     p2_reg;
    logic            neg2_reg;
    logic [19:0]     q;
    logic [19:0]     q_sat;
    logic signed [OW-1:0] angle_reg;

    assign mag   = (zero_in || !a_in[AW-1]) ? (zero_in ? '0 : AW'(a_in)) : AW'(-a_in);
    assign q     = p2_reg[43:24];
    assign q_sat = (q > 20'(LIMIT)) ? 20'(LIMIT) : q;

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_reg    <= 52'(mag) * ANGLE_GAIN + ANGLE_BIAS;
            neg1_reg  <= a_in[AW-1] && !zero_in;
            p2_reg    <= 44'(p1_reg[51:31]) * RECIP_5;
            neg2_reg  <= neg1_reg;
            angle_reg <= neg2_reg ? -OW'(q_sat) : OW'(q_sat);
        end
    end

    assign angle_out = angle_reg;
endmodule
`default_nettype wire

@@ src/quaternion_to_euler_angles.sv @@
// Quaternion to Euler angle converter: top level pipeline.
// Depends on qte_pkg, qte_sqrt_cell, qte_cordic_pre, qte_cordic_cell, qte_angle_scale.
//
// Usage:
//   Input channel s_*: one sensor report per item (Q30 quaternion, z gyro
//   sample, quaternion-present flag). Result channel m_*: pitch and yaw in
//   1/64 degree, roll as gyro rate in 1/64 degree per second, and updated.
//   One item is accepted every cycle unless a result waits with m_ready low;
//   each item passes through the 31-cell square root chain followed by
//   the CORDIC cell row before the angles are scaled to the m_* outputs.
//   A report without a quaternion passes through the pipeline in order and
//   returns the last computed angles with updated low.
//   When m_ready is low while a result waits, the whole pipeline holds and
//   s_ready drops; nothing is dropped or repeated.
//   Reset clears all valid flags and the held angles to zero.
`timescale 1ns / 1ps
`default_nettype none
module quaternion_to_euler_angles #(
    parameter int CORDIC_STAGES = 16
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic signed [31:0] s_quat_w,
    input  wire logic signed [31:0] s_quat_x,
    input  wire logic signed [31:0] s_quat_y,
    input  wire logic signed [31:0] s_quat_z,
    input  wire logic signed [15:0] s_gyro_rate_z,
    input  wire logic               s_quat_present,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [13:0]      m_pitch_angle,
    output logic signed [17:0]      m_roll_value,
    output logic signed [14:0]      m_yaw_angle,
    output logic                    m_updated
);
    import qte_pkg::*;

    localparam int LAT = 38 + CORDIC_STAGES;

    logic en;

    logic [LAT-1:0] vld_reg;
    logic [LAT-1:0] pres_reg;
    logic signed [17:0] roll_reg [LAT-2];

    // stage 1
    logic signed [63:0] wy_reg, xz_reg, xy_reg, wz_reg;
    logic signed [63:0] ww_reg, xx_reg, yy_reg, zz_reg;
    logic signed [16:0] g_ext;
    logic [16:0]        g_abs;
    logic [23:0]        gn_next;
    logic [23:0]        gn_reg;
    logic               gneg_reg;

    // stage 2
    logic signed [63:0] s_full, ny_full, nx_full;
    logic signed [31:0] s_next;
    logic signed [31:0] s2_reg;
    logic signed [35:0] ny2_reg, nx2_reg;
    logic [47:0]        rp_reg;
    logic [23:0]        gn2_reg;
    logic               gneg2_reg;

    // stage 3
    logic signed [63:0] ss_full;
    logic [17:0]        q0;
    logic [24:0]        rem;
    logic [17:0]        rq;
    logic signed [17:0] roll_next;
    sq_t                ss_reg;
    logic signed [31:0] s3_reg;
    logic signed [35:0] ny3_reg, nx3_reg;

    sq_t sq_v [SQ_CELLS+1];
    sq_t sq_r [SQ_CELLS+1];
    logic signed [31:0] sd_reg  [SQ_CELLS];
    logic signed [35:0] nyd_reg [SQ_CELLS];
    logic signed [35:0] nxd_reg [SQ_CELLS];

    cxy_t  px [CORDIC_STAGES+1];
    cxy_t  py [CORDIC_STAGES+1];
    cang_t pa [CORDIC_STAGES+1];
    logic  pz [CORDIC_STAGES+1];
    cxy_t  yx [CORDIC_STAGES+1];
    cxy_t  yy [CORDIC_STAGES+1];
    cang_t ya [CORDIC_STAGES+1];
    logic  yz [CORDIC_STAGES+1];

    logic signed [13:0] pitch_q;
    logic signed [14:0] yaw_q;

    logic               m_valid_reg;
    logic signed [13:0] pitch_reg;
    logic signed [17:0] roll_out_reg;
    logic signed [14:0] yaw_reg;
    logic               upd_reg;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    // control line
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LAT-2:0], s_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pres_reg    <= {pres_reg[LAT-2:0], s_quat_present};
            roll_reg[0] <= roll_next;
            for (int i = 1; i < LAT - 2; i++) begin
                roll_reg[i] <= roll_reg[i-1];
            end
        end
    end

    // stage 1: products
    assign g_ext   = 17'(s_gyro_rate_z);
    assign g_abs   = g_ext[16] ? 17'(-g_ext) : 17'(g_ext);
    assign gn_next = (24'(g_abs) << 8) + (24'(g_abs) << 6) + 24'd41;

    always_ff @(posedge aclk) begin
        if (en) begin
            wy_reg   <= s_quat_w * s_quat_y;
            xz_reg   <= s_quat_x * s_quat_z;
            xy_reg   <= s_quat_x * s_quat_y;
            wz_reg   <= s_quat_w * s_quat_z;
            ww_reg   <= s_quat_w * s_quat_w;
            xx_reg   <= s_quat_x * s_quat_x;
            yy_reg   <= s_quat_y * s_quat_y;
            zz_reg   <= s_quat_z * s_quat_z;
            gn_reg   <= gn_next;
            gneg_reg <= s_gyro_rate_z[15];
        end
    end

    // stage 2: sums, sine clamp, roll reciprocal product
    assign s_full  = (wy_reg >>> 29) - (xz_reg >>> 29);
    assign ny_full = (xy_reg >>> 29) + (wz_reg >>> 29);
    assign nx_full = (ww_reg >>> 30) + (xx_reg >>> 30) - (yy_reg >>> 30) - (zz_reg >>> 30);

    always_comb begin
        if (s_full > 64'sh40000000) begin
            s_next = 32'sh40000000;
        end else if (s_full < -64'sh40000000) begin
            s_next = -32'sh40000000;
        end else begin
            s_next = s_full[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s2_reg    <= s_next;
            ny2_reg   <= ny_full[35:0];
            nx2_reg   <= nx_full[35:0];
            rp_reg    <= 48'(gn_reg) * RECIP_82;
            gn2_reg   <= gn_reg;
            gneg2_reg <= gneg_reg;
        end
    end

    // stage 3: sine squared, roll correction
    assign ss_full   = s2_reg * s2_reg;
    assign q0        = rp_reg[47:30];
    assign rem       = 25'(gn2_reg) - 25'(q0) * 25'd82;
    assign rq        = (rem >= 25'd82) ? q0 + 18'd1 : q0;
    assign roll_next = gneg2_reg ? -18'(rq) : 18'(rq);

    always_ff @(posedge aclk) begin
        if (en) begin
            ss_reg  <= ss_full[SQ_W-1:0];
            s3_reg  <= s2_reg;
            ny3_reg <= ny2_reg;
            nx3_reg <= nx2_reg;
        end
    end

    // cosine by square root cell row
    assign sq_v[0] = (SQ_W'(1) << 60) - ss_reg;
    assign sq_r[0] = '0;

    for (genvar k = 0; k < SQ_CELLS; k++) begin : g_sqrt
        qte_sqrt_cell #(.BIT_POS(60 - 2 * k)) u_cell (
            .aclk  (aclk),
            .en    (en),
            .v_in  (sq_v[k]),
            .r_in  (sq_r[k]),
            .v_out (sq_v[k+1]),
            .r_out (sq_r[k+1])
        );
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sd_reg[0]  <= s3_reg;
            nyd_reg[0] <= ny3_reg;
            nxd_reg[0] <= nx3_reg;
            for (int i = 1; i < SQ_CELLS; i++) begin
                sd_reg[i]  <= sd_reg[i-1];
                nyd_reg[i] <= nyd_reg[i-1];
                nxd_reg[i] <= nxd_reg[i-1];
            end
        end
    end

    // pitch and yaw CORDIC rows
    qte_cordic_pre u_pitch_pre (
        .aclk     (aclk),
        .en       (en),
        .x_in     (cxy_t'(sq_r[SQ_CELLS][30:0])),
        .y_in     (cxy_t'(sd_reg[SQ_CELLS-1])),
        .x_out    (px[0]),
        .y_out    (py[0]),
        .a_out    (pa[0]),
        .zero_out (pz[0])
    );

    qte_cordic_pre u_yaw_pre (
        .aclk     (aclk),
        .en       (en),
        .x_in     (cxy_t'(nxd_reg[SQ_CELLS-1])),
        .y_in     (cxy_t'(nyd_reg[SQ_CELLS-1])),
        .x_out    (yx[0]),
        .y_out    (yy[0]),
        .a_out    (ya[0]),
        .zero_out (yz[0])
    );

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
        qte_cordic_cell #(.IDX(i)) u_pitch_cell (
            .aclk     (aclk),
            .en       (en),
            .x_in     (px[i]),
            .y_in     (py[i]),
            .a_in     (pa[i]),
            .zero_in  (pz[i]),
            .x_out    (px[i+1]),
            .y_out    (py[i+1]),
            .a_out    (pa[i+1]),
            .zero_out (pz[i+1])
        );
        qte_cordic_cell #(.IDX(i)) u_yaw_cell (
            .aclk     (aclk),
            .en       (en),
            .x_in     (yx[i]),
            .y_in     (yy[i]),
            .a_in     (ya[i]),
            .zero_in  (yz[i]),
            .x_out    (yx[i+1]),
            .y_out    (yy[i+1]),
            .a_out    (ya[i+1]),
            .zero_out (yz[i+1])
        );
    end

    qte_angle_scale #(.OW(14), .LIMIT(PITCH_LIMIT)) u_pitch_scale (
        .aclk      (aclk),
        .en        (en),
        .a_in      (pa[CORDIC_STAGES]),
        .zero_in   (pz[CORDIC_STAGES]),
        .angle_out (pitch_q)
    );

    qte_angle_scale #(.OW(15), .LIMIT(YAW_LIMIT)) u_yaw_scale (
        .aclk      (aclk),
        .en        (en),
        .a_in      (ya[CORDIC_STAGES]),
        .zero_in   (yz[CORDIC_STAGES]),
        .angle_out (yaw_q)
    );

    // output register, holds the last angles
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg  <= 1'b0;
            upd_reg      <= 1'b0;
            pitch_reg    <= '0;
            roll_out_reg <= '0;
            yaw_reg      <= '0;
        end else if (en) begin
            m_valid_reg <= vld_reg[LAT-1];
            if (vld_reg[LAT-1]) begin
                upd_reg <= pres_reg[LAT-1];
                if (pres_reg[LAT-1]) begin
                    pitch_reg    <= pitch_q;
                    roll_out_reg <= roll_reg[LAT-3];
                    yaw_reg      <= yaw_q;
                end
            end
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_pitch_angle = pitch_reg;
    assign m_roll_value  = roll_out_reg;
    assign m_yaw_angle   = yaw_reg;
    assign m_updated     = upd_reg;
endmodule
`default_nettype wire
